// File: design/lbf_pkg.sv
`timescale 1ns / 1ps
package lbf_pkg;

  localparam int ADDR_COUNT = 128;
  localparam int ADDR_W     = $clog2(ADDR_COUNT);
  localparam int MAX_PORTS  = 16;
  localparam int PORT_W     = 4;
  localparam int MASK_W     = 16;
  localparam int NPORT_W    = 5;
  localparam int BADDR_W    = 7;
  localparam int STA_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_PORTS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BCAST     = CFG_IDX_W'(1);

  localparam logic [NPORT_W-1:0] NUM_PORTS_RST = NPORT_W'(4);
  localparam logic [BADDR_W-1:0] BCAST_RST     = BADDR_W'(99);

  // One frame header as it waits between front and back.
  typedef struct packed {
    logic [STA_W-1:0]  src;
    logic [STA_W-1:0]  dst;
    logic [PORT_W-1:0] port;
    logic              bcast;
  } lbf_item_t;

endpackage

// File: design/learning_bridge_forwarder.sv
`timescale 1ns / 1ps
// Channel  Handshake         Payload
// in       start & !busy     src_addr, dst_addr, in_port
// out      done (one cycle)  out_ports, flooded, learned
// cfg      cfg_we            cfg_idx, cfg_data
//
// Back end: B_IDLE pops a word and reads the table, registered (source and
// destination on the two read ports); B_LOOK then does update and result.
// busy rises only when the two-entry queue is full; the receiver cannot stall.
// Synchronous reset clears all learned-entry valid bits at once; no sweep.
module learning_bridge_forwarder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [lbf_pkg::STA_W-1:0]      src_addr,
  input  logic [lbf_pkg::STA_W-1:0]      dst_addr,
  input  logic [lbf_pkg::PORT_W-1:0]     in_port,
  input  logic                          cfg_we,
  input  logic [lbf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lbf_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          done,
  output logic [lbf_pkg::MASK_W-1:0]     out_ports,
  output logic                          flooded,
  output logic                          learned
);
  import lbf_pkg::*;

  logic [NPORT_W-1:0] num_ports;
  logic [BADDR_W-1:0] broadcast_addr;
  logic               head_valid;
  lbf_item_t          head;
  logic               pop;

  // configuration registers; writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      num_ports      <= NUM_PORTS_RST;
      broadcast_addr <= BCAST_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_NUM_PORTS: num_ports      <= cfg_data[NPORT_W-1:0];
        REG_BCAST:     broadcast_addr <= cfg_data[BADDR_W-1:0];
        default:       ;
      endcase
    end
  end

  // front end: accept the header, flag broadcast, queue it
  lbf_front u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .src_addr       (src_addr),
    .dst_addr       (dst_addr),
    .in_port        (in_port),
    .broadcast_addr (broadcast_addr),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop)
  );

  // back end: table lookup, learning and forwarding decision
  lbf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .num_ports  (num_ports),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .done       (done),
    .out_ports  (out_ports),
    .flooded    (flooded),
    .learned    (learned)
  );

endmodule

// File: design/lbf_ram.sv
`timescale 1ns / 1ps
module lbf_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: design/lbf_front.sv
`timescale 1ns / 1ps
module lbf_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [lbf_pkg::STA_W-1:0]   src_addr,
  input  logic [lbf_pkg::STA_W-1:0]   dst_addr,
  input  logic [lbf_pkg::PORT_W-1:0]  in_port,
  input  logic [lbf_pkg::BADDR_W-1:0] broadcast_addr,
  output logic                       head_valid,
  output lbf_pkg::lbf_item_t         head,
  input  logic                       pop
);
  import lbf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  lbf_item_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                push;
  lbf_item_t           item;

  assign busy       = (count == CNT_W'(QUEUE_DEPTH));
  assign push       = start && !busy;
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // classify on entry: user keeps broadcast register stable while words are in flight; not enforced
  always_comb begin
    item.src   = src_addr;
    item.dst   = dst_addr;
    item.port  = in_port;
    item.bcast = (dst_addr == broadcast_addr);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/lbf_back.sv
`timescale 1ns / 1ps
module lbf_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [lbf_pkg::NPORT_W-1:0] num_ports,
  input  logic                       head_valid,
  input  lbf_pkg::lbf_item_t         head,
  output logic                       pop,
  output logic                       done,
  output logic [lbf_pkg::MASK_W-1:0]  out_ports,
  output logic                       flooded,
  output logic                       learned
);
  import lbf_pkg::*;

  typedef enum logic {
    B_IDLE,
    B_LOOK
  } state_t;

  state_t              state;
  lbf_item_t           cur;
  logic [ADDR_COUNT-1:0] vld;
  logic [PORT_W-1:0]   rd_src;
  logic [PORT_W-1:0]   rd_dst;

  logic [ADDR_W-1:0]   si;
  logic [ADDR_W-1:0]   di;
  logic                src_known;
  logic [PORT_W-1:0]   src_port;
  logic                dst_known;
  logic [PORT_W-1:0]   dst_port;
  logic                flood;
  logic [NPORT_W-1:0]  lim;
  logic [MASK_W-1:0]   mask;
  logic                wr_en;

  assign pop = (state == B_IDLE) && head_valid;

  lbf_ram #(
    .WIDTH (PORT_W),
    .DEPTH (ADDR_COUNT)
  ) u_table (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (si),
    .wdata   (cur.port),
    .raddr_a (head.src[ADDR_W-1:0]),
    .rdata_a (rd_src),
    .raddr_b (head.dst[ADDR_W-1:0]),
    .rdata_b (rd_dst)
  );

  always_comb begin
    si        = cur.src[ADDR_W-1:0];
    di        = cur.dst[ADDR_W-1:0];
    src_known = vld[si];
    src_port  = src_known ? rd_src : cur.port;
    // learning comes first, so a frame to its own source sees the new entry
    if (si == di) begin
      dst_known = 1'b1;
      dst_port  = src_port;
    end else begin
      dst_known = vld[di];
      dst_port  = rd_dst;
    end
    flood = cur.bcast || !dst_known;
    lim   = (num_ports > NPORT_W'(MAX_PORTS)) ? NPORT_W'(MAX_PORTS) : num_ports;
    for (int i = 0; i < MASK_W; i++) begin
      mask[i] = flood ? ((NPORT_W'(i) < lim) && (PORT_W'(i) != src_port))
                      : (PORT_W'(i) == dst_port);
    end
    wr_en = (state == B_LOOK) && !src_known;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[si] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (head_valid) begin
            state <= B_LOOK;
          end
        end
        B_LOOK: begin
          done      <= 1'b1;
          out_ports <= mask;
          flooded   <= flood;
          learned   <= !src_known;
          state     <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_done_after_look: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == B_LOOK))
    else $error("result strobe without a lookup");

  a_learn_sticks: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> vld[$past(si)])
    else $error("learned entry not marked valid");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == B_LOOK) && !pop)
    else $error("second word popped during lookup");

  a_learned_flag: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> done && learned)
    else $error("table write without learned flag");
`endif

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import lbf_pkg::*;

  // Forwarding decision for one frame header, as the block should report it.
  typedef struct packed {
    logic [MASK_W-1:0] ports;
    logic              flood;
    logic              learn;
  } fwd_t;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [STA_W-1:0]      src_addr;
  logic [STA_W-1:0]      dst_addr;
  logic [PORT_W-1:0]     in_port;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  done;
  logic [MASK_W-1:0]     out_ports;
  logic                  flooded;
  logic                  learned;

  // Shadow of the bridge: register copies and the station table.
  // Table entries hold port + 1; zero means the station is still unknown.
  logic [NPORT_W-1:0] shadow_nports;
  logic [BADDR_W-1:0] shadow_bcast;
  logic [PORT_W:0]    station_port [ADDR_COUNT];

  fwd_t             expected_fwd [$];  // decisions still owed by the block
  logic [STA_W-1:0] recent_src [$];    // stations seen lately, for known-destination traffic
  fwd_t             head;
  int               mismatches = 0;
  int               gap_pct;            // chance in a hundred of a sender gap before a word

  learning_bridge_forwarder i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .src_addr  (src_addr),
    .dst_addr  (dst_addr),
    .in_port   (in_port),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .done      (done),
    .out_ports (out_ports),
    .flooded   (flooded),
    .learned   (learned)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Learn first, then forward: the source entry is written before the
  // destination lookup, so a frame to its own source returns on its port.
  function automatic fwd_t forward_decision(input logic [STA_W-1:0] s,
                                            input logic [STA_W-1:0] d,
                                            input logic [PORT_W-1:0] p);
    fwd_t            r;
    int              n;
    logic [MASK_W:0] all_ports;
    logic [PORT_W:0] port_idx;
    r = '0;
    if (station_port[s] == '0) begin
      station_port[s] = {1'b0, p} + 1'b1;
      r.learn = 1'b1;
    end
    if (d == shadow_bcast || station_port[d] == '0) begin
      // Flood: clip the port count to what the mask can hold, drop the
      // source's own learned port (not necessarily the arrival port).
      n = int'(shadow_nports);
      if (n > MAX_PORTS) n = MAX_PORTS;
      if (n > MASK_W) n = MASK_W;
      all_ports = ((MASK_W+1)'(1) << n) - 1'b1;
      r.ports = all_ports[MASK_W-1:0];
      port_idx = station_port[s] - 1'b1;
      if (port_idx < MASK_W) r.ports[port_idx] = 1'b0;
      r.flood = 1'b1;
    end else begin
      // Known station: its learned port only, even if out of use or the
      // arrival port itself.
      port_idx = station_port[d] - 1'b1;
      if (port_idx < MASK_W) r.ports[port_idx] = 1'b1;
    end
    return r;
  endfunction

  // Offer one header and hold it until busy is low at an edge. start stays
  // high on return so back-to-back words go out without a bubble.
  task automatic send_word(input logic [STA_W-1:0] s, input logic [STA_W-1:0] d,
                           input logic [PORT_W-1:0] p);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start    <= 1'b1;
    src_addr <= s;
    dst_addr <= d;
    in_port  <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_fwd = {expected_fwd, forward_decision(s, d, p)};
    recent_src = {recent_src, s};
    if (recent_src.size() > 16) void'(recent_src.pop_front());
  endtask

  // Let the pipe run dry; every word gives a result, so once no decision is
  // still owed the block is idle.
  task automatic wait_quiet();
    start <= 1'b0;
    while (expected_fwd.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    wait_quiet();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_NUM_PORTS) shadow_nports = value[NPORT_W-1:0];
    else if (idx == REG_BCAST) shadow_bcast = value[BADDR_W-1:0];
  endtask

  // Known stations now and then so that learned forwarding is exercised,
  // not only flooding.
  function automatic logic [STA_W-1:0] pick_station(input int known_pct);
    if (recent_src.size() != 0 && $urandom_range(0, 99) < known_pct)
      return recent_src[$urandom_range(0, recent_src.size() - 1)];
    return STA_W'($urandom_range(0, ADDR_COUNT - 1));
  endfunction

  // Reset register values; learning before forwarding, broadcast vs unknown
  // vs known destinations, arrival ports outside the ports in use.
  task automatic test_forwarding_basics();
    send_word(7'd0,   7'd0,   4'd0);   // own source as destination, first sight
    send_word(7'd127, 7'd99,  4'd15);  // broadcast from a port not in use
    send_word(7'd1,   7'd127, 4'd2);   // known station behind port 15
    send_word(7'd2,   7'd50,  4'd3);   // unknown destination floods
    send_word(7'd3,   7'd1,   4'd2);   // known destination is the arrival port
    send_word(7'd99,  7'd5,   4'd1);   // broadcast address learnt as a source
    send_word(7'd4,   7'd99,  4'd0);   // still broadcast though now learnt
    send_word(7'd0,   7'd127, 4'd9);   // known source seen on a new port: no move
    send_word(7'd127, 7'd0,   4'd0);
    send_word(7'd5,   7'd5,   4'd7);
  endtask

  // Port count extremes: none, one, full, beyond the mask; broadcast
  // address at both ends of its range.
  task automatic test_register_extremes();
    write_reg(REG_NUM_PORTS, CFG_DATA_W'(0));
    send_word(7'd6, 7'd99, 4'd1);      // flood reaching no port
    send_word(7'd7, 7'd60, 4'd2);
    write_reg(REG_NUM_PORTS, CFG_DATA_W'(1));
    send_word(7'd8, 7'd99, 4'd0);      // only port is the source's own
    send_word(7'd9, 7'd61, 4'd3);
    write_reg(REG_NUM_PORTS, CFG_DATA_W'(16));
    send_word(7'd10, 7'd99, 4'd15);
    send_word(7'd11, 7'd62, 4'd4);
    write_reg(REG_NUM_PORTS, CFG_DATA_W'(31));
    send_word(7'd12, 7'd99, 4'd6);
    send_word(7'd13, 7'd63, 4'd15);
    write_reg(REG_NUM_PORTS, CFG_DATA_W'(17));
    send_word(7'd14, 7'd64, 4'd8);
    write_reg(REG_BCAST, CFG_DATA_W'(0));
    send_word(7'd15, 7'd0, 4'd1);      // station 0 is known but now broadcast
    send_word(7'd16, 7'd99, 4'd2);     // old broadcast address, now a station
    write_reg(REG_BCAST, CFG_DATA_W'(127));
    send_word(7'd17, 7'd127, 4'd3);
    send_word(7'd127, 7'd17, 4'd5);
  endtask

  // Fresh register values, then a stream of random headers at the given
  // sender gap rate.
  task automatic test_random_traffic(input int gap, input int count);
    logic [STA_W-1:0] s;
    logic [STA_W-1:0] d;
    int               pick;
    if ($urandom_range(0, 3) == 0)
      write_reg(REG_NUM_PORTS, CFG_DATA_W'($urandom_range(0, 31)));
    else
      write_reg(REG_NUM_PORTS, CFG_DATA_W'($urandom_range(1, 16)));
    write_reg(REG_BCAST, CFG_DATA_W'($urandom_range(0, ADDR_COUNT - 1)));
    gap_pct = gap;
    for (int k = 0; k < count; k++) begin
      s    = pick_station(25);
      pick = $urandom_range(0, 9);
      if (pick < 2) d = shadow_bcast;
      else d = pick_station(40);
      send_word(s, d, PORT_W'($urandom_range(0, 15)));
    end
    gap_pct = 0;
  endtask

  // Results cannot be held off, so every done pulse is checked at the
  // edge that ends it.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_fwd.size() == 0) begin
        $error("unexpected word: out_ports %h flooded %b learned %b",
               out_ports, flooded, learned);
        mismatches++;
      end else begin
        head = expected_fwd.pop_front();
        if (out_ports !== head.ports) begin
          $error("out_ports: expected %h, got %h", head.ports, out_ports);
          mismatches++;
        end
        if (flooded !== head.flood) begin
          $error("flooded: expected %b, got %b", head.flood, flooded);
          mismatches++;
        end
        if (learned !== head.learn) begin
          $error("learned: expected %b, got %b", head.learn, learned);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst      <= 1'b1;
    start    <= 1'b0;
    src_addr <= '0;
    dst_addr <= '0;
    in_port  <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= '0;
    cfg_data <= '0;
    gap_pct       = 0;
    shadow_nports = NUM_PORTS_RST;
    shadow_bcast  = BCAST_RST;
    foreach (station_port[i]) station_port[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_forwarding_basics();
    test_register_extremes();
    test_random_traffic(19, 150);
    test_random_traffic(48, 150);
    test_random_traffic(0, 150);

    // Drain with a bound, then a short tail to catch stray pulses.
    start <= 1'b0;
    for (int k = 0; k < 200 && expected_fwd.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_fwd.size() != 0) begin
      $error("%0d words never came out", expected_fwd.size());
    end
    if (mismatches == 0 && expected_fwd.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog: ends a run that hangs and reports errors.
  initial begin
    #1_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// File: files.f
design/lbf_pkg.sv
design/lbf_ram.sv
design/lbf_front.sv
design/lbf_back.sv
design/learning_bridge_forwarder.sv
sim/tb_top.sv
